/* sv/rational_arithmetic_unit_macros.svh */
// Assertion macros shared by the checker.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored during reset.
`define RAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rational_arithmetic_unit assertion failed");

// Next-cycle implication, sampled on clk and ignored during reset.
`define RAU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rational_arithmetic_unit assertion failed");

`endif

/* sv/rau_pkg.sv */
`timescale 1ns / 1ps
package rau_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_CMP  = 3'd4,
    ACT_NEG  = 3'd5,
    ACT_INC  = 3'd6,
    ACT_NORM = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    ORD_LT = 2'd0,
    ORD_EQ = 2'd1,
    ORD_GT = 2'd2
  } order_code_t;

  typedef enum logic [1:0] {
    SEL_P = 2'd0,
    SEL_Q = 2'd1,
    SEL_D = 2'd2
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_Q,
    S_MUL_D,
    S_CHECK,
    S_GCD,
    S_DINIT_N,
    S_DIV_N,
    S_DINIT_D,
    S_DIV_D,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     gcd_init;
    logic     gcd_step;
    logic     div_init;
    logic     div_den;
    logic     div_step;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_last;
  } status_t;

endpackage

/* sv/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Rational arithmetic unit: exact add, subtract, multiply, divide, compare,
// negate, increment and normalize on signed fractions, reduced by gcd.
// Input: drive in_action and the four operand ports and raise start; the
// word is taken at a clock edge where start is high and busy is low. The
// unit works on one word at a time and holds busy high until its result
// has been shown.
// Output: out_valid is high for exactly one cycle with out_result_num,
// out_result_den, out_order and out_status; the receiver cannot stall and
// must take the word in that cycle.
// Sequence with VALUE_WIDTH = W: the controller forms the products in S_MUL_P,
// S_MUL_Q and S_MUL_D and checks them; compare, zero results and divide-by-zero
// words then go straight to the result step. Other words run a binary gcd on
// the 2W+1 bit magnitudes and then two bit-serial quotient divisions that
// share one subtractor; the gcd loop and the divisions set how long such a
// word takes. busy drops in the cycle after the strobe, so the next word can
// be taken in that cycle.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// any word in flight; the result ports keep their last value.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_left_num,
  input  logic [31:0] in_left_den,
  input  logic [31:0] in_right_num,
  input  logic [31:0] in_right_den,
  output logic        out_valid,
  output logic [31:0] out_result_num,
  output logic [30:0] out_result_den,
  output logic [1:0]  out_order,
  output logic [1:0]  out_status
);

  cmd_t    cmd;
  status_t sts;

  rau_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rau_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .in_action      (in_action),
    .in_left_num    (in_left_num),
    .in_left_den    (in_left_den),
    .in_right_num   (in_right_num),
    .in_right_den   (in_right_den),
    .sts            (sts),
    .out_result_num (out_result_num),
    .out_result_den (out_result_den),
    .out_order      (out_order),
    .out_status     (out_status)
  );

endmodule

/* sv/rau_datapath.sv */
`timescale 1ns / 1ps
module rau_datapath import rau_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  cmd_t        cmd,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_left_num,
  input  logic [31:0] in_left_den,
  input  logic [31:0] in_right_num,
  input  logic [31:0] in_right_den,
  output status_t     sts,
  output logic [31:0] out_result_num,
  output logic [30:0] out_result_den,
  output logic [1:0]  out_order,
  output logic [1:0]  out_status
);

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam int GW = 2 * W + 1;
  localparam int KW = $clog2(GW + 1);
  localparam int CW = $clog2(GW);
  localparam logic [GW-1:0] LIM = {{(GW - W + 1){1'b0}}, {(W - 1){1'b1}}};

  action_t               action_r;
  logic signed [W-1:0]   ln_r, ld_r, rn_r, rd_r;
  logic                  dz_r;
  logic signed [PW-1:0]  p_r, q_r, d_r;
  logic                  nneg_r;
  logic [GW-1:0]         nmag_r;
  logic [GW-1:0]         a_r, b_r, g_r;
  logic [KW-1:0]         k_r;
  logic [GW-1:0]         quo_r, nq_r, dq_r;
  logic [GW:0]           rem_r;
  logic [CW-1:0]         cnt_r;
  logic                  den_sel_r;
  logic [31:0]           res_num_r;
  logic [30:0]           res_den_r;
  logic [1:0]            order_r, status_r;

  // Operands are the low VALUE_WIDTH bits of each port, taken as signed.
  logic signed [W-1:0] in_ln, in_ld, in_rn, in_rd;
  logic                in_dz;
  assign in_ln = in_left_num[W-1:0];
  assign in_ld = in_left_den[W-1:0];
  assign in_rn = in_right_num[W-1:0];
  assign in_rd = in_right_den[W-1:0];

  always_comb begin
    case (action_t'(in_action)) inside
      ACT_DIV:                    in_dz = (in_rd == '0) || (in_ld == '0) || (in_rn == '0);
      ACT_NEG, ACT_INC, ACT_NORM: in_dz = (in_ld == '0);
      default:                    in_dz = (in_ld == '0) || (in_rd == '0);
    endcase
  end

  // One shared signed multiplier, its operands picked per product.
  logic signed [W-1:0]  ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [W-1:0]  one_w;
  assign one_w = W'(1);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      SEL_P: begin
        case (action_r) inside
          ACT_MUL:           begin ma = ln_r; mb = rn_r;  end
          ACT_NEG:           begin ma = '0;   mb = '0;    end
          ACT_INC, ACT_NORM: begin ma = ln_r; mb = one_w; end
          default:           begin ma = ln_r; mb = rd_r;  end
        endcase
      end
      SEL_Q: begin
        case (action_r) inside
          ACT_ADD, ACT_SUB, ACT_CMP: begin ma = rn_r; mb = ld_r;  end
          ACT_NEG:                   begin ma = ln_r; mb = one_w; end
          ACT_INC:                   begin ma = ld_r; mb = one_w; end
          default:                   begin ma = '0;   mb = '0;    end
        endcase
      end
      SEL_D: begin
        case (action_r) inside
          ACT_DIV:                    begin ma = ld_r; mb = rn_r;  end
          ACT_NEG, ACT_INC, ACT_NORM: begin ma = ld_r; mb = one_w; end
          default:                    begin ma = ld_r; mb = rd_r;  end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  logic                 do_sub;
  logic signed [GW-1:0] sum;
  logic [GW-1:0]        sum_mag;
  assign do_sub  = (action_r == ACT_SUB) || (action_r == ACT_CMP) || (action_r == ACT_NEG);
  assign sum     = do_sub ? (GW'(p_r) - GW'(q_r)) : (GW'(p_r) + GW'(q_r));
  assign sum_mag = sum[GW-1] ? GW'(-sum) : GW'(sum);

  logic [GW-1:0] dmag;
  assign dmag = GW'($unsigned(d_r[PW-1] ? -d_r : d_r));

  logic nzero, is_cmp;
  assign nzero  = (nmag_r == '0);
  assign is_cmp = (action_r == ACT_CMP);

  assign sts.special  = dz_r || nzero || is_cmp;
  assign sts.gcd_done = (a_r == '0) || (b_r == '0);
  assign sts.div_last = (cnt_r == CW'(GW - 1));

  // Restoring division step.
  logic [GW:0]   rsh;
  logic          ge;
  logic [GW:0]   rem_nxt;
  logic [GW-1:0] quo_nxt;
  assign rsh     = {rem_r[GW-1:0], quo_r[GW-1]};
  assign ge      = (rsh >= {1'b0, g_r});
  assign rem_nxt = ge ? (rsh - {1'b0, g_r}) : rsh;
  assign quo_nxt = {quo_r[GW-2:0], ge};

  // Final result selection.
  logic                neg, less, ovf;
  logic signed [W-1:0] res_w;
  assign neg   = nneg_r ^ d_r[PW-1];
  assign less  = nneg_r ^ (ld_r[W-1] ^ rd_r[W-1]);
  assign ovf   = (dq_r > LIM) || (nq_r > (LIM + GW'(neg)));
  assign res_w = W'(neg ? -nq_r : nq_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= action_t'(in_action);
      ln_r     <= in_ln;
      ld_r     <= in_ld;
      rn_r     <= in_rn;
      rd_r     <= in_rd;
      dz_r     <= in_dz;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        SEL_P: p_r <= prod;
        SEL_Q: q_r <= prod;
        SEL_D: begin
          d_r    <= prod;
          nneg_r <= sum[GW-1];
          nmag_r <= sum_mag;
        end
        default: ;
      endcase
    end
    // Binary gcd: one halving or one subtraction per cycle.
    if (cmd.gcd_init) begin
      a_r <= nmag_r;
      b_r <= dmag;
      k_r <= '0;
    end else if (cmd.gcd_step) begin
      if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r >= b_r) begin
        a_r <= a_r - b_r;
      end else begin
        b_r <= b_r - a_r;
      end
    end
    if (cmd.div_init) begin
      if (!cmd.div_den) begin
        g_r <= (a_r | b_r) << k_r;
      end
      quo_r     <= cmd.div_den ? dmag : nmag_r;
      rem_r     <= '0;
      cnt_r     <= '0;
      den_sel_r <= cmd.div_den;
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CW'(1);
      if (sts.div_last) begin
        if (den_sel_r) begin
          dq_r <= quo_nxt;
        end else begin
          nq_r <= quo_nxt;
        end
      end
    end
    if (cmd.finish) begin
      res_num_r <= 32'd0;
      res_den_r <= 31'd1;
      order_r   <= ORD_LT;
      status_r  <= ST_OK;
      if (dz_r) begin
        status_r <= ST_DIV0;
      end else if (is_cmp) begin
        order_r <= nzero ? ORD_EQ : (less ? ORD_LT : ORD_GT);
      end else if (!nzero) begin
        if (ovf) begin
          status_r <= ST_OVF;
        end else begin
          res_num_r <= 32'(res_w);
          res_den_r <= 31'(dq_r);
        end
      end
    end
  end

  assign out_result_num = res_num_r;
  assign out_result_den = res_den_r;
  assign out_order      = order_r;
  assign out_status     = status_r;

endmodule

/* sv/rau_controller.sv */
`timescale 1ns / 1ps
module rau_controller import rau_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t sts,
  output cmd_t    cmd,
  output logic    busy,
  output logic    out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (start) state_nxt = S_MUL_P;
      S_MUL_P:   state_nxt = S_MUL_Q;
      S_MUL_Q:   state_nxt = S_MUL_D;
      S_MUL_D:   state_nxt = S_CHECK;
      S_CHECK:   state_nxt = sts.special ? S_FIN : S_GCD;
      S_GCD:     if (sts.gcd_done) state_nxt = S_DINIT_N;
      S_DINIT_N: state_nxt = S_DIV_N;
      S_DIV_N:   if (sts.div_last) state_nxt = S_DINIT_D;
      S_DINIT_D: state_nxt = S_DIV_D;
      S_DIV_D:   if (sts.div_last) state_nxt = S_FIN;
      S_FIN:     state_nxt = S_OUT;
      S_OUT:     state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = SEL_P;
    case (state_r)
      S_IDLE:  cmd.load = start;
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_P;
      end
      S_MUL_Q: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_Q;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_D;
      end
      S_CHECK:   cmd.gcd_init = !sts.special;
      S_GCD:     cmd.gcd_step = !sts.gcd_done;
      S_DINIT_N: cmd.div_init = 1'b1;
      S_DIV_N:   cmd.div_step = 1'b1;
      S_DINIT_D: begin
        cmd.div_init = 1'b1;
        cmd.div_den  = 1'b1;
      end
      S_DIV_D:   cmd.div_step = 1'b1;
      S_FIN:     cmd.finish = 1'b1;
      default:   ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

/* sv/rau_checker.sv */
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_macros.svh"
module rau_checker import rau_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_result_num,
  input logic [30:0] out_result_den,
  input logic [1:0]  out_order,
  input logic [1:0]  out_status
);

  // An accepted word keeps the unit busy in the next cycle.
  `RAU_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // A result strobe lasts one cycle and is followed by idle.
  `RAU_ASSERT_NXT(a_strobe_single, out_valid, !out_valid && !busy)
  // Any error status returns the fraction zero over one.
  `RAU_ASSERT_IMP(a_err_zero, out_valid && (out_status != ST_OK),
                  (out_result_num == 32'd0) && (out_result_den == 31'd1))
  // A delivered denominator is never zero.
  `RAU_ASSERT_IMP(a_den_nonzero, out_valid, out_result_den != 31'd0)

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_result_num (out_result_num),
  .out_result_den (out_result_den),
  .out_order      (out_order),
  .out_status     (out_status)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import rau_pkg::*;

  typedef struct packed {
    logic [31:0]  num;
    logic [30:0]  den;
    order_code_t  ord;
    status_code_t st;
  } fraction_word_t;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 400;
  localparam longint MAX_MAG = 64'd2147483647;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_action = ACT_ADD;
  logic [31:0] in_left_num = '0;
  logic [31:0] in_left_den = 32'd1;
  logic [31:0] in_right_num = '0;
  logic [31:0] in_right_den = 32'd1;
  logic        out_valid;
  logic [31:0] out_result_num;
  logic [30:0] out_result_den;
  logic [1:0]  out_order;
  logic [1:0]  out_status;

  fraction_word_t expected_words[$];
  int  error_count = 0;
  int  stall_count = 0;
  bit  idle_on = 1'b1;

  rational_arithmetic_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_left_num(in_left_num), .in_left_den(in_left_den),
    .in_right_num(in_right_num), .in_right_den(in_right_den),
    .out_valid(out_valid), .out_result_num(out_result_num),
    .out_result_den(out_result_den), .out_order(out_order), .out_status(out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reduces n/d by the gcd and applies the sign, zero and range rules.
  function automatic fraction_word_t reduce_fraction(logic signed [64:0] n, longint d);
    fraction_word_t r;
    logic [64:0] nm, dm, a, b, t;
    logic neg;
    r.num = '0;
    r.den = 31'd1;
    r.ord = ORD_LT;
    r.st  = ST_OK;
    if (d == 0) begin
      r.st = ST_DIV0;
      return r;
    end
    if (n == 0) return r;
    neg = (n < 0) != (d < 0);
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? 65'(-d) : 65'(d);
    a = nm;
    b = dm;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    nm = nm / a;
    dm = dm / a;
    if (dm > MAX_MAG || nm > (neg ? MAX_MAG + 1 : MAX_MAG)) begin
      r.st = ST_OVF;
    end else begin
      r.num = neg ? -nm[31:0] : nm[31:0];
      r.den = dm[30:0];
    end
    return r;
  endfunction

  function automatic fraction_word_t predict_fraction(action_t act, logic [31:0] ln_w,
      logic [31:0] ld_w, logic [31:0] rn_w, logic [31:0] rd_w);
    fraction_word_t r;
    longint ln, ld, rn, rd;
    logic signed [64:0] cross_l, cross_r, diff;
    ln = longint'(signed'(ln_w));
    ld = longint'(signed'(ld_w));
    rn = longint'(signed'(rn_w));
    rd = longint'(signed'(rd_w));
    cross_l = ln * rd;
    cross_r = rn * ld;
    r = reduce_fraction(65'sd0, 1);
    case (act)
      ACT_ADD: r = reduce_fraction(cross_l + cross_r, ld * rd);
      ACT_SUB: r = reduce_fraction(cross_l - cross_r, ld * rd);
      ACT_MUL: r = reduce_fraction(65'(ln * rn), ld * rd);
      ACT_DIV: begin
        if (rd == 0) r.st = ST_DIV0;
        else r = reduce_fraction(cross_l, ld * rn);
      end
      ACT_CMP: begin
        if (ld == 0 || rd == 0) begin
          r.st = ST_DIV0;
        end else begin
          diff = cross_l - cross_r;
          if (diff == 0) r.ord = ORD_EQ;
          else r.ord = ((diff < 0) != ((ld < 0) != (rd < 0))) ? ORD_LT : ORD_GT;
        end
      end
      ACT_NEG: r = reduce_fraction(-65'(ln), ld);
      ACT_INC: r = reduce_fraction(65'(ln) + 65'(ld), ld);
      default: r = reduce_fraction(65'(ln), ld);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("Mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_word(action_t act, logic [31:0] ln, logic [31:0] ld,
      logic [31:0] rn, logic [31:0] rd);
    if (idle_on && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start        <= 1'b1;
    in_action    <= act;
    in_left_num  <= ln;
    in_left_den  <= ld;
    in_right_num <= rn;
    in_right_den <= rd;
    do @(posedge clk); while (busy);
    expected_words.push_back(predict_fraction(act, ln, ld, rn, rd));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_result_num, 0);
      end else begin
        fraction_word_t w;
        w = expected_words.pop_front();
        if (out_result_num !== w.num) report_mismatch("result_num", out_result_num, w.num);
        if (out_result_den !== w.den) report_mismatch("result_den", out_result_den, w.den);
        if (out_order !== w.ord) report_mismatch("order", out_order, w.ord);
        if (out_status !== w.st) report_mismatch("status", out_status, w.st);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mix of small values, extremes, powers of two and full-range words.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0, 1: return 32'($signed($urandom_range(0, 40)) - 20);
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h8000_0001;
          3: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      3: return $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
                                     : -(32'd1 << $urandom_range(0, 31));
      4: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_denominator();
    if ($urandom_range(0, 49) == 0) return '0;
    return pick_operand();
  endfunction

  task automatic test_directed();
    action_t act;
    send_word(ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_word(ACT_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_word(ACT_MUL, -32'd2, 32'd3, 32'd3, -32'd4);
    send_word(ACT_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
    send_word(ACT_DIV, 32'd1, 32'd2, 32'd3, 32'd0);
    send_word(ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_word(ACT_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
    send_word(ACT_CMP, -32'd1, 32'd2, 32'd1, -32'd3);
    send_word(ACT_CMP, 32'd1, -32'd2, 32'd1, 32'd3);
    send_word(ACT_CMP, 32'd1, 32'd0, 32'd1, 32'd3);
    send_word(ACT_NEG, 32'h8000_0000, 32'd1, 32'd5, 32'd0);
    send_word(ACT_NEG, 32'h8000_0000, 32'h8000_0000, 32'd5, 32'd0);
    send_word(ACT_INC, 32'h7fff_ffff, 32'd1, 32'd0, 32'd0);
    send_word(ACT_INC, -32'd3, 32'd3, 32'd0, 32'd0);
    send_word(ACT_NORM, 32'd6, -32'd4, 32'hffff_ffff, 32'd0);
    send_word(ACT_NORM, 32'd1, 32'h8000_0000, 32'd0, 32'd1);
    send_word(ACT_NORM, 32'd0, -32'd7, 32'd0, 32'd1);
    send_word(ACT_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send_word(ACT_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001);
    send_word(ACT_SUB, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
    send_word(ACT_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_word(ACT_CMP, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_word(ACT_NORM, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd1);
    act = ACT_SUB;
    send_word(act, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);
  endtask

  task automatic test_random(int count);
    repeat (count) begin
      send_word(action_t'($urandom_range(0, 7)), pick_operand(), pick_denominator(),
                pick_operand(), pick_denominator());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    // A long run with the sender never pausing.
    idle_on = 1'b0;
    test_random(500);
    idle_on = 1'b1;
    test_random(700);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* rational_arithmetic_unit.f */
+incdir+sv
sv/rau_pkg.sv
sv/rau_datapath.sv
sv/rau_controller.sv
sv/rational_arithmetic_unit.sv
sv/rau_checker.sv
tb/testbench.sv
